### rtl/nca_pkg.sv
// Shared constants, codes and types for the nearest-centroid assignment block.
// No dependencies; every other file but nca_ram imports this package.
package nca_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_FEATURES = 16;
    localparam int STORE_DEPTH  = MAX_CLUSTERS * MAX_FEATURES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // field widths of the transactions
    localparam int CIDX_W  = 4;
    localparam int FIDX_W  = 4;
    localparam int VALUE_W = 16;
    localparam int NEAR_W  = 4;
    localparam int COUNT_W = 5;
    localparam int LIMIT_W = 36;
    localparam int CFG_IDX_W = 1;

    // datapath widths
    localparam int DIFF_W = VALUE_W + 1;
    localparam int SQ_W   = 2 * VALUE_W;
    localparam int SUM_W  = 37;
    localparam int CELL_W = $clog2(MAX_CLUSTERS);
    localparam int USE_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int CMP_W  = (USE_W > COUNT_W) ? USE_W : COUNT_W;

    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(16);
    localparam logic [LIMIT_W-1:0] RESET_LIMIT = LIMIT_W'((1 << 16) - 1);

    // operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = CFG_IDX_W'(1);

    // token handed from cell to cell: a record feature or the compare sweep
    typedef struct packed {
        logic                      feat;
        logic                      cmp;
        logic signed [VALUE_W-1:0] value;
        logic [LIMIT_W-1:0]        best;
        logic [CELL_W-1:0]         who;
        logic                      found;
    } t_token;

    // centroid component broadcast from the store read port
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] data;
    } t_bus;

endpackage

### rtl/nca_ifs.sv
// Channel interfaces: item input, result output and configuration write.
// Depends on nca_pkg for field widths.
interface nca_item_if import nca_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [CIDX_W-1:0]         cluster_index;
    logic [FIDX_W-1:0]         feature_index;
    logic signed [VALUE_W-1:0] value;
    logic                      last_of_record;

    modport source (output valid, operation, cluster_index, feature_index, value,
                    last_of_record, input ready);
    modport sink   (input valid, operation, cluster_index, feature_index, value,
                    last_of_record, output ready);
endinterface

interface nca_result_if import nca_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NEAR_W-1:0]  nearest_cluster;
    logic               found;
    logic [LIMIT_W-1:0] best_distance;

    modport source (output valid, nearest_cluster, found, best_distance, input ready);
    modport sink   (input valid, nearest_cluster, found, best_distance, output ready);
endinterface

interface nca_cfg_if import nca_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LIMIT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/nearest_centroid_assign_unit.sv
// Top level of the nearest-centroid assignment block: sequencer, centroid
// store, configuration registers, cell chain and result register.
// Depends on nca_pkg, nca_ifs, nca_ram and nca_cell.
//
//  channel   role    fields
//  --------  ------  ----------------------------------------------------------
//  i_item    sink    operation, cluster_index, feature_index, value, last_of_record
//  o_result  source  nearest_cluster, found, best_distance
//  i_cfg     sink    index (0 cluster_count, 1 distance_limit), data
//
// A load transaction is taken in the idle state. A feature blocks the input for
// N store reads, N being the clusters in use: the store's single read port gives
// one centroid component a cycle. The last feature of a record adds the drain and
// the compare sweep down the 16-cell chain, plus any wait for the result register:
// the sweep only starts once it is empty. Synchronous active-low reset sets
// cluster_count to 16, distance_limit to 65535 and clears all sums; store
// contents are undefined until loaded. Configuration is always ready.
module nearest_centroid_assign_unit import nca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nca_item_if.sink   i_item,
    nca_result_if.source o_result,
    nca_cfg_if.sink    i_cfg
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FEED = 2'd1;   // one store read per cluster
    localparam logic [1:0] ST_WAIT = 2'd2;   // let the cell pipelines settle
    localparam logic [1:0] ST_CMP  = 2'd3;   // compare sweep in flight
    localparam logic [1:0] WAIT_LAST = 2'd2;

    // configuration
    logic [COUNT_W-1:0] r_count;
    logic [LIMIT_W-1:0] r_limit;
    logic [USE_W-1:0]   w_in_use;

    // sequencer
    logic [1:0]          r_state, n_state;
    logic [USE_W-1:0]    r_k, n_k;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [1:0]          r_wait, n_wait;
    logic                r_last, n_last;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic                r_rd_valid;

    // store ports
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic                w_re;
    logic [VALUE_W-1:0]  w_rdata;

    // chain
    t_token w_head;
    t_token w_tok [MAX_CLUSTERS+1];
    t_bus   w_bus;
    logic   w_accept;

    // result register
    logic               r_out_valid;
    logic [NEAR_W-1:0]  r_out_near;
    logic               r_out_found;
    logic [LIMIT_W-1:0] r_out_best;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= RESET_COUNT;
            r_limit <= RESET_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CLUSTER_COUNT:  r_count <= i_cfg.data[COUNT_W-1:0];
                CFG_DISTANCE_LIMIT: r_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // counts above the cell row saturate
    always_comb begin
        if (CMP_W'(r_count) > CMP_W'(MAX_CLUSTERS)) begin
            w_in_use = USE_W'(MAX_CLUSTERS);
        end else begin
            w_in_use = USE_W'(r_count);
        end
    end

    // ---------------- input and store ----------------
    assign i_item.ready = (r_state == ST_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;

    // out-of-range loads are dropped
    assign w_we = w_accept && (i_item.operation == OP_LOAD)
                  && (int'(i_item.cluster_index) < MAX_CLUSTERS)
                  && (int'(i_item.feature_index) < MAX_FEATURES);
    assign w_waddr = ADDR_W'(i_item.cluster_index) * ADDR_W'(MAX_FEATURES)
                     + ADDR_W'(i_item.feature_index);
    assign w_re = (r_state == ST_FEED);

    nca_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_item.value),
        .i_re   (w_re),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_addr  = r_addr;
        n_wait  = r_wait;
        n_last  = r_last;
        n_value = r_value;
        w_head  = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_item.operation == OP_CLASSIFY)) begin
                    n_value = i_item.value;
                    n_last  = i_item.last_of_record;
                    n_addr  = ADDR_W'(i_item.feature_index);
                    n_k     = '0;
                    n_wait  = '0;
                    // a feature past the store or no clusters: nothing to add
                    if ((int'(i_item.feature_index) < MAX_FEATURES)
                        && (w_in_use != '0)) begin
                        n_state = ST_FEED;
                    end else if (i_item.last_of_record) begin
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_FEED: begin
                // feature token leaves with the first read, so cell k meets
                // its centroid component on the bus
                if (r_k == '0) begin
                    w_head.feat  = 1'b1;
                    w_head.value = r_value;
                end
                n_addr = r_addr + ADDR_W'(MAX_FEATURES);
                n_k    = r_k + USE_W'(1);
                if (r_k == (w_in_use - USE_W'(1))) begin
                    n_state = r_last ? ST_WAIT : ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (r_wait != WAIT_LAST) begin
                    n_wait = r_wait + 2'd1;
                end else if (!r_out_valid) begin
                    w_head.cmp  = 1'b1;
                    w_head.best = r_limit;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (w_tok[MAX_CLUSTERS].cmp) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_addr  <= n_addr;
        r_wait  <= n_wait;
        r_last  <= n_last;
        r_value <= n_value;
    end

    // ---------------- cell chain ----------------
    assign w_bus.valid = r_rd_valid;
    assign w_bus.data  = $signed(w_rdata);
    assign w_tok[0]    = w_head;

    for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
        nca_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (CELL_W'(k)),
            .i_in_use(w_in_use),
            .i_bus   (w_bus),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tok[MAX_CLUSTERS].cmp) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[MAX_CLUSTERS].cmp) begin
            r_out_near  <= NEAR_W'(w_tok[MAX_CLUSTERS].who);
            r_out_found <= w_tok[MAX_CLUSTERS].found;
            r_out_best  <= w_tok[MAX_CLUSTERS].best;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.nearest_cluster = r_out_near;
    assign o_result.found           = r_out_found;
    assign o_result.best_distance   = r_out_best;

endmodule

### rtl/nca_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No package dependency.
module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/nca_cell.sv
// One cluster cell: holds that cluster's distance sum, squares and adds
// feature differences, and takes part in the compare sweep. Uses nca_pkg.
module nca_cell import nca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CELL_W-1:0] i_index,
    input  logic [USE_W-1:0]  i_in_use,
    input  t_bus              i_bus,
    input  t_token            i_tok,
    output t_token            o_tok
);

    t_token                    r_tok;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [DIFF_W-1:0]  n_diff;
    logic                      r_diff_v;
    logic                      n_diff_v;
    logic [SQ_W-1:0]           r_sq;
    logic [SQ_W-1:0]           n_sq;
    logic                      r_sq_v;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          n_sum;
    logic signed [2*DIFF_W-1:0] w_prod;
    logic [SUM_W:0]            w_acc;
    logic                      w_active;
    logic                      w_better;

    always_comb begin
        w_active = USE_W'(i_index) < i_in_use;

        // a cell out of use keeps its sum: an older feature token passing
        // while the next feature is on the bus must not add to it
        n_diff_v = r_tok.feat && i_bus.valid && w_active;
        n_diff   = DIFF_W'(i_bus.data) - DIFF_W'(r_tok.value);
        w_prod   = r_diff * r_diff;
        n_sq     = w_prod[SQ_W-1:0];
        w_acc    = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);

        w_better = r_tok.cmp && w_active && (r_sum < SUM_W'(r_tok.best));

        n_sum = r_sum;
        if (r_tok.cmp) begin
            n_sum = '0;                          // sweep clears every sum
        end else if (r_sq_v) begin
            n_sum = w_acc[SUM_W] ? SUM_MAX : w_acc[SUM_W-1:0];
        end

        o_tok = r_tok;
        if (w_better) begin
            o_tok.best  = r_sum[LIMIT_W-1:0];
            o_tok.who   = i_index;
            o_tok.found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.feat <= 1'b0;
            r_tok.cmp  <= 1'b0;
            r_diff_v   <= 1'b0;
            r_sq_v     <= 1'b0;
            r_sum      <= '0;
        end else begin
            r_tok    <= i_tok;
            r_diff_v <= n_diff_v;
            r_sq_v   <= r_diff_v;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_sq   <= n_sq;
    end

endmodule

### tb/nearest_centroid_assign_unit_test.sv
// Self-checking testbench for nearest_centroid_assign_unit: random and directed
// load/classify traffic against a cycle-free predictor held in a scoreboard class.
// Depends on nca_pkg, the nca_ifs channel interfaces and the block's RTL.
module nearest_centroid_assign_unit_test;
    import nca_pkg::*;

    localparam int ITEM_TARGET    = 950;
    localparam int SETTLE_CYCLES  = 64;    // worst feature plus drain and sweep, with margin
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7fff;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;
    // (32767 - -32768)^2: one feature at opposite extremes
    localparam logic [LIMIT_W-1:0] SPAN_SQUARED = 36'd4294836225;
    // sixteen such features: the largest distance a full record can reach
    localparam logic [LIMIT_W-1:0] FULL_SPAN    = 36'd68717379600;

    typedef struct packed {
        logic [NEAR_W-1:0]  cluster;
        logic               found;
        logic [LIMIT_W-1:0] distance;
    } t_assignment;

    // Mirrors the block: centroid store, per-cluster sums and both registers.
    // Every accepted item is fed in order; records that end queue an assignment.
    class centroid_matcher;
        logic signed [VALUE_W-1:0] centroids [STORE_DEPTH];
        logic [SUM_W-1:0]          sums [MAX_CLUSTERS];
        logic [COUNT_W-1:0]        cluster_count;
        logic [LIMIT_W-1:0]        distance_limit;
        t_assignment               assignments_due [$];
        int                        mismatches;

        function new();
            foreach (centroids[i]) centroids[i] = '0;
            foreach (sums[i]) sums[i] = '0;
            cluster_count  = RESET_COUNT;
            distance_limit = RESET_LIMIT;
            mismatches     = 0;
        endfunction

        function int unsigned in_use();
            return (cluster_count > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(cluster_count);
        endfunction

        function int pending();
            return assignments_due.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [LIMIT_W-1:0] data);
            if (index == CFG_CLUSTER_COUNT) begin
                cluster_count = data[COUNT_W-1:0];
            end else if (index == CFG_DISTANCE_LIMIT) begin
                distance_limit = data;
            end
        endfunction

        function void take_item(logic op, logic [CIDX_W-1:0] cidx, logic [FIDX_W-1:0] fidx,
                                logic signed [VALUE_W-1:0] val, logic last);
            int unsigned        n;
            longint             diff;
            logic [63:0]        acc;
            logic [SUM_W-1:0]   best;
            t_assignment        pick;
            if (op == OP_LOAD) begin
                centroids[int'(cidx) * MAX_FEATURES + int'(fidx)] = val;
                return;
            end
            n = in_use();
            for (int k = 0; k < n; k++) begin
                diff = longint'(centroids[k * MAX_FEATURES + int'(fidx)]) - longint'(val);
                acc  = 64'(sums[k]) + 64'(diff * diff);
                sums[k] = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
            end
            if (!last) return;
            best          = SUM_W'(distance_limit);
            pick.cluster  = '0;
            pick.found    = 1'b0;
            for (int k = 0; k < n; k++) begin
                if (sums[k] < best) begin
                    best         = sums[k];
                    pick.cluster = NEAR_W'(k);
                    pick.found   = 1'b1;
                end
            end
            pick.distance = best[LIMIT_W-1:0];
            assignments_due.insert(assignments_due.size(), pick);
            foreach (sums[k]) sums[k] = '0;
        endfunction

        function void match_result(logic [NEAR_W-1:0] cluster, logic found,
                                   logic [LIMIT_W-1:0] distance);
            t_assignment want;
            if (assignments_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: cluster %0d found %0b distance %0d",
                         $time, cluster, found, distance);
                return;
            end
            want = assignments_due.pop_front();
            if (cluster !== want.cluster) begin
                mismatches++;
                $display("%0t: nearest_cluster expected %0d, got %0d",
                         $time, want.cluster, cluster);
            end
            if (found !== want.found) begin
                mismatches++;
                $display("%0t: found expected %0b, got %0b", $time, want.found, found);
            end
            if (distance !== want.distance) begin
                mismatches++;
                $display("%0t: best_distance expected %0d, got %0d",
                         $time, want.distance, distance);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    nca_item_if   item_ch ();
    nca_result_if result_ch ();
    nca_cfg_if    cfg_ch ();

    nearest_centroid_assign_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    centroid_matcher sb;
    int  items_sent  = 0;
    int  quiet_cycles = 0;
    bit  steady      = 1'b0;   // set for whole phases with no idling on either side
    bit  open_record = 1'b0;   // a classify record has started but not yet ended

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gap length for either side: mostly back to back, some short, a few long.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Feature value: near a chosen centroid (small distances, ties), at an
    // extreme, or anywhere in range.
    function automatic logic signed [VALUE_W-1:0] feature_value(int k, int f);
        int                        v;
        int                        r;
        logic signed [VALUE_W-1:0] pick;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            v = int'(sb.centroids[k * MAX_FEATURES + f]) + int'($urandom_range(0, 40)) - 20;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            pick = VALUE_W'(v);
        end else if (r == 4) begin
            pick = VALUE_MAX;
        end else if (r == 5) begin
            pick = VALUE_MIN;
        end else begin
            pick = VALUE_W'($urandom);
        end
        return pick;
    endfunction

    // Valid is left high after acceptance; the next call either keeps it high
    // (no gap) or drops it for the gap, so it only ever moves once per edge.
    // Anything that stops sending must drop valid itself.
    task automatic send_item(input logic op, input logic [CIDX_W-1:0] cidx,
                             input logic [FIDX_W-1:0] fidx,
                             input logic signed [VALUE_W-1:0] val, input logic last);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.operation      <= op;
        item_ch.cluster_index  <= cidx;
        item_ch.feature_index  <= fidx;
        item_ch.value          <= val;
        item_ch.last_of_record <= last;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.take_item(op, cidx, fidx, val, last);
        items_sent++;
        if (op == OP_CLASSIFY) open_record = !last;
    endtask

    // Leaves cfg valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [LIMIT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(index, data);
    endtask

    // Registers only change on an idle block: every assignment back, then a
    // settle for loads or features still in flight that produce nothing.
    task automatic reconfigure(input bit set_count, input logic [COUNT_W-1:0] count,
                               input bit set_limit, input logic [LIMIT_W-1:0] limit);
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (set_count) write_reg(CFG_CLUSTER_COUNT, LIMIT_W'(count));
        if (set_limit) write_reg(CFG_DISTANCE_LIMIT, limit);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random phase: new settings, then a mix of well-formed records,
    // load bursts and loose features, closed off by a record end.
    task automatic run_phase();
        int                 budget;
        int                 r;
        int                 len;
        int                 f0;
        int                 k;
        int unsigned        n;
        logic [COUNT_W-1:0] count;
        logic [LIMIT_W-1:0] limit;
        r = $urandom_range(0, 9);
        if (r == 0)      count = '0;
        else if (r == 1) count = COUNT_W'(1);
        else if (r == 2) count = COUNT_W'(MAX_CLUSTERS);
        else if (r == 3) count = COUNT_W'($urandom_range(MAX_CLUSTERS + 1, 31));
        else             count = COUNT_W'($urandom_range(2, MAX_CLUSTERS));
        r = $urandom_range(0, 9);
        if (r == 0)      limit = '0;
        else if (r == 1) limit = '1;
        else if (r == 2) limit = FULL_SPAN;
        else if (r == 3) limit = {4'($urandom), 32'($urandom)};
        else if (r < 7)  limit = LIMIT_W'($urandom_range(0, 200000));
        else             limit = LIMIT_W'($urandom);
        reconfigure($urandom_range(0, 2) != 0, count, $urandom_range(0, 2) != 0, limit);
        steady = ($urandom_range(0, 3) == 0);
        n      = sb.in_use();
        k      = 0;
        budget = $urandom_range(20, 80);
        while (budget > 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // well-formed record aimed at one cluster; now and then overlong
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, MAX_FEATURES);
                f0  = $urandom_range(0, MAX_FEATURES - 1);
                k   = (n > 0) ? $urandom_range(0, n - 1) : 0;
                for (int j = 0; j < len; j++) begin
                    send_item(OP_CLASSIFY, CIDX_W'($urandom), FIDX_W'(f0 + j),
                              feature_value(k, (f0 + j) % MAX_FEATURES), j == len - 1);
                end
                budget -= len;
            end else if (r < 80) begin
                // centroid rewrites, possibly in the middle of a record
                len = $urandom_range(1, 5);
                for (int j = 0; j < len; j++) begin
                    send_item(OP_LOAD, CIDX_W'($urandom), FIDX_W'($urandom),
                              VALUE_W'($urandom), 1'($urandom));
                end
                budget -= len;
            end else begin
                // loose feature: any index, repeats allowed, ends a record now and then
                f0 = $urandom_range(0, MAX_FEATURES - 1);
                send_item(OP_CLASSIFY, CIDX_W'($urandom), FIDX_W'(f0), feature_value(k, f0),
                          $urandom_range(0, 3) == 0);
                budget--;
            end
        end
        if (open_record) begin
            send_item(OP_CLASSIFY, CIDX_W'($urandom), FIDX_W'($urandom),
                      VALUE_W'($urandom), 1'b1);
        end
    endtask

    // Result side: ready stalls drawn like the sender's gaps.
    initial begin : result_sink
        int span;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            span = idle_span();
            if (span > 0) begin
                result_ch.ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Results are checked as they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            sb.match_result(result_ch.nearest_cluster, result_ch.found, result_ch.best_distance);
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic signed [VALUE_W-1:0] v;
        sb = new();
        i_rst_n                <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.operation      <= OP_LOAD;
        item_ch.cluster_index  <= '0;
        item_ch.feature_index  <= '0;
        item_ch.value          <= '0;
        item_ch.last_of_record <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= CFG_CLUSTER_COUNT;
        cfg_ch.data            <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole store first so no classify ever reads an unwritten
        // entry. Cluster 0 sits at the negative extreme and cluster 15 at the
        // positive one; the rest are random, some on a coarse grid for ties.
        for (int a = 0; a < STORE_DEPTH; a++) begin
            if (a / MAX_FEATURES == 0)
                v = VALUE_MIN;
            else if (a / MAX_FEATURES == MAX_CLUSTERS - 1)
                v = VALUE_MAX;
            else if ($urandom_range(0, 3) == 0)
                v = VALUE_W'((int'($urandom_range(0, 4)) - 2) * 1000);
            else
                v = VALUE_W'($urandom);
            send_item(OP_LOAD, CIDX_W'(a / MAX_FEATURES), FIDX_W'(a % MAX_FEATURES), v,
                      1'($urandom));
        end

        // Directed: registers still at their reset values here.
        send_item(OP_CLASSIFY, 4'd7, 4'd0, VALUE_MIN, 1'b1);
        send_item(OP_LOAD, 4'd1, 4'd0, VALUE_MIN, 1'b0);     // cluster 1 ties cluster 0
        send_item(OP_LOAD, 4'd2, 4'd0, VALUE_MAX, 1'b1);     // end flag on a load: no result
        send_item(OP_CLASSIFY, 4'd15, 4'd0, VALUE_MIN, 1'b1); // tie: lowest index wins
        send_item(OP_CLASSIFY, 4'd0, 4'd0, VALUE_MAX, 1'b1);  // exact hit on cluster 2
        // same feature index three times in one record: all three add up
        send_item(OP_CLASSIFY, 4'd3, 4'd15, VALUE_MIN, 1'b0);
        send_item(OP_CLASSIFY, 4'd3, 4'd15, VALUE_MIN, 1'b0);
        send_item(OP_CLASSIFY, 4'd3, 4'd15, VALUE_MAX, 1'b1);

        // no clusters in use: nothing compared, limit comes back
        reconfigure(1'b1, '0, 1'b0, '0);
        send_item(OP_CLASSIFY, 4'd0, 4'd5, VALUE_MAX, 1'b1);
        // count beyond the store saturates; widest limit
        reconfigure(1'b1, 5'd31, 1'b1, '1);
        send_item(OP_CLASSIFY, 4'd15, 4'd3, 16'sd1234, 1'b1);
        // limit equal to the only distance: not strictly below
        reconfigure(1'b1, 5'd1, 1'b1, SPAN_SQUARED);
        send_item(OP_CLASSIFY, 4'd0, 4'd0, VALUE_MAX, 1'b1);
        // one above it: found
        reconfigure(1'b0, '0, 1'b1, SPAN_SQUARED + 1);
        send_item(OP_CLASSIFY, 4'd0, 4'd0, VALUE_MAX, 1'b1);
        // limit zero: even a perfect match is not below it
        reconfigure(1'b0, '0, 1'b1, '0);
        send_item(OP_CLASSIFY, 4'd0, 4'd0, VALUE_MIN, 1'b1);

        // Full-width record at opposite extremes: largest reportable distance.
        reconfigure(1'b0, '0, 1'b1, '1);
        for (int f = 0; f < MAX_FEATURES; f++)
            send_item(OP_CLASSIFY, 4'd0, FIDX_W'(f), VALUE_MAX, f == MAX_FEATURES - 1);
        // Same again, but with the limit at exactly that distance.
        reconfigure(1'b0, '0, 1'b1, FULL_SPAN);
        for (int f = 0; f < MAX_FEATURES; f++)
            send_item(OP_CLASSIFY, 4'd9, FIDX_W'(f), VALUE_MAX, f == MAX_FEATURES - 1);
        // Runaway record: the sum runs into its ceiling and stays there.
        reconfigure(1'b0, '0, 1'b1, '1);
        for (int f = 0; f < 40; f++)
            send_item(OP_CLASSIFY, CIDX_W'($urandom), FIDX_W'(f), VALUE_MAX, f == 39);

        while (items_sent < ITEM_TARGET) run_phase();

        // Drain: everything back, then let the block go quiet.
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/nca_pkg.sv
rtl/nca_ifs.sv
rtl/nca_ram.sv
rtl/nca_cell.sv
rtl/nearest_centroid_assign_unit.sv
tb/nearest_centroid_assign_unit_test.sv
